// File: src/ple_pkg.sv
`timescale 1ns / 1ps

package ple_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int CMD_W     = 3;
	localparam int POS_W     = 7;
	localparam int VAL_W     = 32;
	localparam int ST_W      = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT  = 3'd0,
		CMD_DEL_POS = 3'd1,
		CMD_DEL_VAL = 3'd2,
		CMD_SEARCH  = 3'd3,
		CMD_DISPLAY = 3'd4
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_RANGE    = 3'd2,
		ST_FULL     = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	// One result as it sits in the output register.
	typedef struct packed {
		status_t          status;
		logic [VAL_W-1:0] value;
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] count;
		logic             last;
	} res_t;

endpackage

// File: src/ple_cmd_if.sv
`timescale 1ns / 1ps

interface ple_cmd_if import ple_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [POS_W-1:0] position;
	logic [VAL_W-1:0] value;

	modport source (output valid, output cmd, output position, output value, input ready);
	modport sink (input valid, input cmd, input position, input value, output ready);
endinterface

// File: src/ple_res_if.sv
`timescale 1ns / 1ps

interface ple_res_if import ple_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ST_W-1:0]  status;
	logic [VAL_W-1:0] item_value;
	logic [POS_W-1:0] item_position;
	logic [POS_W-1:0] entry_count;
	logic             last;

	modport source (output valid, output status, output item_value, output item_position,
		output entry_count, output last, input ready);
	modport sink (input valid, input status, input item_value, input item_position,
		input entry_count, input last, output ready);
endinterface

// File: src/positional_list_engine.sv
`timescale 1ns / 1ps

// An error goes straight to S_FIN for its result. An insert at position p first moves the
// entries from the tail down to p one slot up; a delete of entry t moves those above t down.
// A search compares entries from the head up to the first match, a miss reads them all;
// delete by value then runs the delete. Display streams one entry per cycle while the
// output register can take it; the list RAM port moves or compares one entry per cycle.
// Reset clears the count and control state; RAM contents stay undefined, no clearing pass.
module positional_list_engine import ple_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ple_cmd_if.sink   req,
	ple_res_if.source rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// S_UP opens a gap by moving entries toward the tail, S_DEL closes one,
	// S_SCAN compares entries against the command value, S_DISP streams the list,
	// and S_FIN hands a single result to the output register.
	typedef enum logic [2:0] {
		S_IDLE,
		S_UP,
		S_DEL,
		S_SCAN,
		S_DISP,
		S_FIN
	} state_t;

	state_t           state_q;
	cmd_t             cmd_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    pos_q;
	logic [VAL_W-1:0] val_q;
	logic [CW-1:0]    idx_q;
	logic             more_q;
	logic [CW-1:0]    src_s1;
	logic             rdv_s1;
	status_t          fin_status_q;
	logic [VAL_W-1:0] fin_value_q;
	logic [CW-1:0]    fin_pos_q;
	res_t             res_q;
	logic             res_vld_q;

	logic             can_emit;
	logic [POS_W-1:0] cnt_w;
	logic [CW-1:0]    cnt_dec;
	logic [CW-1:0]    src_inc;
	logic [CW-1:0]    src_dec;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [VAL_W-1:0] rd_data;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [VAL_W-1:0] wr_data;

	ple_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// The output register can take a new result when it is empty or is being drained.
	assign can_emit = !res_vld_q || rsp.ready;
	assign cnt_w    = POS_W'(cnt_q);
	assign cnt_dec  = cnt_q - 1'b1;
	assign src_inc  = src_s1 + 1'b1;
	assign src_dec  = src_s1 - 1'b1;

	// Commands are taken only between commands; a pending result does not block a transfer.
	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid         = res_vld_q;
	assign rsp.status        = res_q.status;
	assign rsp.item_value    = res_q.value;
	assign rsp.item_position = res_q.pos;
	assign rsp.entry_count   = res_q.count;
	assign rsp.last          = res_q.last;

	// RAM port control. Reads are issued from idx_q; the data of the address in src_s1
	// arrives in the cycle after the read. A shift writes one slot behind (delete) or ahead
	// (insert) of the entry just read, so read and write addresses never meet in one cycle.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = src_s1[AW-1:0];
		wr_data = rd_data;
		unique case (state_q)
			S_UP: begin
				rd_en = more_q;
				if (rdv_s1) begin
					wr_en   = 1'b1;
					wr_addr = src_inc[AW-1:0];
				end else if (!more_q) begin
					// Every entry has moved: drop the new value into the gap.
					wr_en   = 1'b1;
					wr_addr = pos_q[AW-1:0];
					wr_data = val_q;
				end
			end
			S_DEL: begin
				rd_en = more_q;
				if (rdv_s1 && (src_s1 != pos_q)) begin
					wr_en   = 1'b1;
					wr_addr = src_dec[AW-1:0];
				end
			end
			S_SCAN: begin
				rd_en = more_q;
			end
			S_DISP: begin
				// Hold the read data while the output register is full.
				rd_en = more_q && (!rdv_s1 || can_emit);
			end
			S_IDLE, S_FIN: begin
				rd_en = 1'b0;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= CMD_INSERT;
			cnt_q        <= '0;
			pos_q        <= '0;
			val_q        <= '0;
			idx_q        <= '0;
			more_q       <= 1'b0;
			src_s1       <= '0;
			rdv_s1       <= 1'b0;
			fin_status_q <= ST_OK;
			fin_value_q  <= '0;
			fin_pos_q    <= '0;
			res_q        <= '0;
			res_vld_q    <= 1'b0;
		end else begin
			if (res_vld_q && rsp.ready) begin
				res_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q       <= cmd_t'(req.cmd);
						val_q       <= req.value;
						rdv_s1      <= 1'b0;
						fin_value_q <= '0;
						fin_pos_q   <= '0;
						case (req.cmd) inside
							CMD_INSERT: begin
								if (req.position > cnt_w) begin
									fin_status_q <= ST_RANGE;
									state_q      <= S_FIN;
								end else if (cnt_q == CW'(DEPTH)) begin
									fin_status_q <= ST_FULL;
									state_q      <= S_FIN;
								end else begin
									// Move entries from the tail down to the insert position.
									pos_q   <= req.position[CW-1:0];
									idx_q   <= cnt_dec;
									more_q  <= (req.position != cnt_w);
									state_q <= S_UP;
								end
							end
							CMD_DEL_POS, CMD_DEL_VAL, CMD_SEARCH, CMD_DISPLAY: begin
								if (cnt_q == '0) begin
									fin_status_q <= ST_EMPTY;
									state_q      <= S_FIN;
								end else if (req.cmd == CMD_DEL_POS) begin
									if (req.position > cnt_w) begin
										fin_status_q <= ST_RANGE;
										state_q      <= S_FIN;
									end else begin
										// A position equal to the count removes the tail entry.
										if (req.position == cnt_w) begin
											pos_q <= cnt_dec;
											idx_q <= cnt_dec;
										end else begin
											pos_q <= req.position[CW-1:0];
											idx_q <= req.position[CW-1:0];
										end
										more_q  <= 1'b1;
										state_q <= S_DEL;
									end
								end else begin
									idx_q   <= '0;
									more_q  <= 1'b1;
									state_q <= (req.cmd == CMD_DISPLAY) ? S_DISP : S_SCAN;
								end
							end
							default: begin
								// Unused codes are dropped without a result.
								state_q <= S_IDLE;
							end
						endcase
					end
				end

				S_UP: begin
					if (more_q) begin
						src_s1 <= idx_q;
						rdv_s1 <= 1'b1;
						if (idx_q == pos_q) begin
							more_q <= 1'b0;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end else begin
						rdv_s1 <= 1'b0;
					end
					if (!more_q && !rdv_s1) begin
						cnt_q        <= cnt_q + 1'b1;
						fin_status_q <= ST_OK;
						state_q      <= S_FIN;
					end
				end

				S_DEL: begin
					if (more_q) begin
						src_s1 <= idx_q;
						rdv_s1 <= 1'b1;
						if (idx_q == cnt_dec) begin
							more_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						rdv_s1 <= 1'b0;
					end
					if (rdv_s1 && (src_s1 == pos_q)) begin
						fin_value_q <= rd_data;
					end
					if (!more_q && !rdv_s1) begin
						cnt_q        <= cnt_dec;
						fin_status_q <= ST_OK;
						fin_pos_q    <= '0;
						state_q      <= S_FIN;
					end
				end

				S_SCAN: begin
					if (more_q) begin
						src_s1 <= idx_q;
						rdv_s1 <= 1'b1;
						if (idx_q == cnt_dec) begin
							more_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						rdv_s1 <= 1'b0;
					end
					if (rdv_s1 && (rd_data == val_q)) begin
						// First match wins; any read still in flight is discarded.
						if (cmd_q == CMD_SEARCH) begin
							fin_status_q <= ST_OK;
							fin_pos_q    <= src_inc;
							state_q      <= S_FIN;
						end else begin
							pos_q   <= src_s1;
							idx_q   <= src_s1;
							more_q  <= 1'b1;
							rdv_s1  <= 1'b0;
							state_q <= S_DEL;
						end
					end else if (!more_q && !rdv_s1) begin
						fin_status_q <= ST_NOTFOUND;
						state_q      <= S_FIN;
					end
				end

				S_DISP: begin
					if (rd_en) begin
						src_s1 <= idx_q;
						rdv_s1 <= 1'b1;
						if (idx_q == cnt_dec) begin
							more_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					if (rdv_s1 && can_emit) begin
						res_q.status <= ST_OK;
						res_q.value  <= rd_data;
						res_q.pos    <= POS_W'(src_s1);
						res_q.count  <= cnt_w;
						res_q.last   <= (src_s1 == cnt_dec);
						res_vld_q    <= 1'b1;
						if (!more_q) begin
							rdv_s1  <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end

				S_FIN: begin
					if (can_emit) begin
						res_q.status <= fin_status_q;
						res_q.value  <= fin_value_q;
						res_q.pos    <= POS_W'(fin_pos_q);
						res_q.count  <= cnt_w;
						res_q.last   <= 1'b1;
						res_vld_q    <= 1'b1;
						state_q      <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The count never passes the capacity of the list.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above capacity");

	// A shift never reads and writes the same RAM slot in one cycle.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("RAM read and write hit the same entry");

	// Closing an insert adds exactly one entry.
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UP && !more_q && !rdv_s1) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("insert did not add one entry");

	// A result is loaded only into an output register that is free or draining.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && !rsp.ready) |=> res_vld_q)
		else $error("pending result lost");

endmodule

// File: src/ple_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write and one registered read per cycle.
module ple_ram import ple_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [VAL_W-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [VAL_W-1:0]         rd_data
);

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
